FILE: src/ikc_pkg.sv
// ----------------------------------------------------------------------------
// Index key collation compare package
// Shared widths, rule codes, order codes and lane status types.
// ----------------------------------------------------------------------------
package ikc_pkg;

   localparam int MAX_KEY_BYTES = 4096;
   localparam int LEN_W  = 13;
   localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int CMP_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
   localparam int BYTE_W = 8;
   localparam int LANES  = 4;
   localparam int WORD_W = BYTE_W * LANES;
   localparam int RULE_W = 8;

   localparam logic [RULE_W-1:0] RULE_BINARY     = 8'h00;
   localparam logic [RULE_W-1:0] RULE_SINGLE     = 8'h10;
   localparam logic [RULE_W-1:0] RULE_HASH_PAIR  = 8'h12;
   localparam logic [RULE_W-1:0] RULE_WORD_ARRAY = 8'h13;

   localparam logic [CMP_W-1:0] SINGLE_LEN = CMP_W'(LANES);
   localparam logic [CMP_W-1:0] PAIR_LEN   = CMP_W'(2 * LANES);
   localparam logic [CMP_W-1:0] MAX_LEN    = CMP_W'(MAX_KEY_BYTES);

   typedef enum logic [1:0] {
      ORD_BEFORE = 2'd0,
      ORD_EQUAL  = 2'd1,
      ORD_AFTER  = 2'd2,
      ORD_ERROR  = 2'd3
   } order_type;

   typedef struct packed {
      logic in_range;
      logic differ;
      logic a_less;
   } lane_status_type;

endpackage

FILE: src/index_key_collation_compare_top.sv
// ----------------------------------------------------------------------------
// Index key collation compare, top level
// Streams two keys as word pairs and reports their collation order.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel carries one 4-byte word of each key
//   plus both key lengths; req_tlast marks the final pair of a comparison.
//   The rsp_ channel returns one order code per comparison: 0 first key
//   before, 1 equal, 2 after, 3 error. The user must write the collation
//   rule on the csr_ channel while the block is idle; the block itself
//   does not enforce this, and csr_ready is always high. Throughput: one
//   request per cycle while req_tready is high. Four byte lanes and a
//   word compare work in parallel on each pair, and the merge folds them
//   into the running verdict in the same cycle, so the verdict loop sets
//   the rate. The response is registered. A two-entry output stage
//   (output register plus skid) lets requests continue while a response
//   waits; req_tready drops only when both entries are full, so a stalled
//   receiver blocks the input after two pending responses.
//   Reset (synchronous, active high) clears the rule to binary, the running
//   verdict to equal, the byte offset to zero and empties the output stage.
// ----------------------------------------------------------------------------
module index_key_collation_compare_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata fields from bit 0: len_a[12:0], len_b[12:0], word_a[31:0],
   // word_b[31:0], zero fill
   input  logic [95:0] req_tdata,
   input  logic        req_tlast,     // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata fields from bit 0: order[1:0], zero fill
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import ikc_pkg::*;

   logic [RULE_W-1:0] rule_ff;
   order_type         verdict_ff, verdict_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              out_valid_ff, out_valid_in;
   order_type         out_order_ff, out_order_in;
   logic              skid_valid_ff, skid_valid_in;
   order_type         skid_order_ff, skid_order_in;

   logic [LEN_W-1:0]  len_a_raw, len_b_raw;
   logic [WORD_W-1:0] word_a, word_b;
   logic [CMP_W-1:0]  len_a, len_b, min_len, offset;
   logic              accept, produce;
   order_type         verdict_next, final_order;
   logic [CMP_W-1:0]  count_sum;
   lane_status_type   lanes [LANES];

   assign len_a_raw = req_tdata[LEN_W-1:0];
   assign len_b_raw = req_tdata[2*LEN_W-1:LEN_W];
   assign word_a    = req_tdata[2*LEN_W+WORD_W-1:2*LEN_W];
   assign word_b    = req_tdata[2*LEN_W+2*WORD_W-1:2*LEN_W+WORD_W];

   assign len_a   = CMP_W'(len_a_raw);
   assign len_b   = CMP_W'(len_b_raw);
   assign min_len = (len_a < len_b) ? len_a : len_b;
   assign offset  = CMP_W'(count_ff);

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign produce    = accept && req_tlast;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_order_ff};

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      ikc_byte_lane u_lane (
         .byte_pos (offset + CMP_W'(g)),
         .min_len  (min_len),
         .byte_a   (word_a[g*BYTE_W +: BYTE_W]),
         .byte_b   (word_b[g*BYTE_W +: BYTE_W]),
         .status   (lanes[g])
      );
   end

   ikc_merge u_merge (
      .lanes        (lanes),
      .word_a       (word_a),
      .word_b       (word_b),
      .offset       (offset),
      .len_a        (len_a),
      .len_b        (len_b),
      .min_len      (min_len),
      .rule         (rule_ff),
      .verdict      (verdict_ff),
      .verdict_next (verdict_next),
      .final_order  (final_order)
   );

   assign count_sum = offset + SINGLE_LEN;

   always_comb begin
      verdict_in = verdict_ff;
      count_in   = count_ff;
      if (accept) begin
         if (req_tlast) begin
            verdict_in = ORD_EQUAL;
            count_in   = '0;
         end else begin
            verdict_in = verdict_next;
            count_in   = (count_sum > MAX_LEN) ? CNT_W'(MAX_KEY_BYTES)
                                               : count_sum[CNT_W-1:0];
         end
      end
   end

   // The skid entry fills only when the output register is held by a stall.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_order_in  = out_order_ff;
      skid_valid_in = skid_valid_ff;
      skid_order_in = skid_order_ff;
      if (out_valid_ff && !rsp_tready) begin
         if (produce) begin
            skid_valid_in = 1'b1;
            skid_order_in = final_order;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_order_in  = skid_order_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = produce;
         out_order_in = final_order;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff       <= RULE_BINARY;
         verdict_ff    <= ORD_EQUAL;
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            rule_ff <= csr_data;
         end
         verdict_ff    <= verdict_in;
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_order_ff  <= out_order_in;
      skid_order_ff <= skid_order_in;
   end

endmodule

FILE: src/ikc_byte_lane.sv
// ----------------------------------------------------------------------------
// Byte lane
// Compares one byte of each key and tells whether the byte lies in both keys.
// ----------------------------------------------------------------------------
module ikc_byte_lane (
   input  logic [ikc_pkg::CMP_W-1:0]  byte_pos,
   input  logic [ikc_pkg::CMP_W-1:0]  min_len,
   input  logic [ikc_pkg::BYTE_W-1:0] byte_a,
   input  logic [ikc_pkg::BYTE_W-1:0] byte_b,
   output ikc_pkg::lane_status_type   status
);
   import ikc_pkg::*;

   always_comb begin
      status.in_range = byte_pos < min_len;
      status.differ   = byte_a != byte_b;
      status.a_less   = byte_a < byte_b;
   end

endmodule

FILE: src/ikc_merge.sv
// ----------------------------------------------------------------------------
// Verdict merge
// Combines the byte lanes and the whole-word compare into the running
// verdict, and resolves the final order on the last word pair.
// ----------------------------------------------------------------------------
module ikc_merge (
   input  ikc_pkg::lane_status_type          lanes [ikc_pkg::LANES],
   input  logic [ikc_pkg::WORD_W-1:0]        word_a,
   input  logic [ikc_pkg::WORD_W-1:0]        word_b,
   input  logic [ikc_pkg::CMP_W-1:0]         offset,
   input  logic [ikc_pkg::CMP_W-1:0]         len_a,
   input  logic [ikc_pkg::CMP_W-1:0]         len_b,
   input  logic [ikc_pkg::CMP_W-1:0]         min_len,
   input  logic [ikc_pkg::RULE_W-1:0]        rule,
   input  ikc_pkg::order_type                verdict,
   output ikc_pkg::order_type                verdict_next,
   output ikc_pkg::order_type                final_order
);
   import ikc_pkg::*;

   logic      word_rule;
   logic      word_fits;
   logic      lane_found;
   order_type lane_order;
   order_type word_order;

   assign word_rule = (rule == RULE_SINGLE) || (rule == RULE_HASH_PAIR) ||
                      (rule == RULE_WORD_ARRAY);
   assign word_fits = (offset + SINGLE_LEN) <= min_len;

   // The lowest lane holding a differing byte inside both keys decides.
   always_comb begin
      lane_found = 1'b0;
      lane_order = ORD_EQUAL;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (lanes[i].in_range && lanes[i].differ) begin
            lane_found = 1'b1;
            lane_order = lanes[i].a_less ? ORD_BEFORE : ORD_AFTER;
         end
      end
   end

   always_comb begin
      if (word_a < word_b) begin
         word_order = ORD_BEFORE;
      end else if (word_a > word_b) begin
         word_order = ORD_AFTER;
      end else begin
         word_order = ORD_EQUAL;
      end
   end

   always_comb begin
      verdict_next = verdict;
      if (verdict == ORD_EQUAL) begin
         if (rule == RULE_BINARY) begin
            if (lane_found) begin
               verdict_next = lane_order;
            end
         end else if (word_rule && word_fits) begin
            verdict_next = word_order;
         end
      end
   end

   always_comb begin
      final_order = ORD_ERROR;
      priority if (len_a > MAX_LEN || len_b > MAX_LEN) begin
         final_order = ORD_ERROR;
      end else if (rule == RULE_BINARY) begin
         final_order = verdict_next;
         if (verdict_next == ORD_EQUAL && len_a != len_b) begin
            final_order = (len_a < len_b) ? ORD_BEFORE : ORD_AFTER;
         end
      end else if (rule == RULE_SINGLE) begin
         if (len_a == SINGLE_LEN && len_b == SINGLE_LEN) begin
            final_order = verdict_next;
         end
      end else if (rule == RULE_HASH_PAIR) begin
         if (len_a == PAIR_LEN && len_b == PAIR_LEN) begin
            final_order = verdict_next;
         end
      end else if (rule == RULE_WORD_ARRAY) begin
         if (len_a == len_b && len_a != '0 && len_a[1:0] == 2'b00) begin
            final_order = verdict_next;
         end
      end else begin
         final_order = ORD_ERROR;
      end
   end

endmodule
